### design/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// No dependencies; every other design file imports this package.
package qrs_pkg;

	localparam int COEF_W = 16;          // Q8.8 coefficient width
	localparam int ROOT_W = 32;          // Q16.16 result width
	localparam int MAG_W  = 33;          // |b^2 - 4ac| magnitude width
	localparam int SQRT_W = 31;          // square root result width
	localparam int RAD_W  = 2 * SQRT_W;  // radicand width, |disc| << 28 padded to even
	localparam int FRAC_SHIFT = 28;      // radicand shift for 14 root fraction bits
	localparam int NUM_W  = 33;          // divider numerator / quotient width
	localparam int DEN_W  = 16;          // divider denominator width
	localparam int NUM_SW = NUM_W + 1;   // signed numerator width

	localparam logic [ROOT_W-1:0] Q16_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
	localparam logic [ROOT_W-1:0] Q16_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_LINEAR  = 2'd0,
		KIND_REAL    = 2'd1,
		KIND_COMPLEX = 2'd2,
		KIND_NONE    = 2'd3
	} root_kind_t;

	// Data that rides beside the square root pipeline
	typedef struct packed {
		root_kind_t               kind;
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] c;
	} sqrt_side_t;

	// Data that rides beside the divider pipeline
	typedef struct packed {
		root_kind_t kind;
		logic       neg1;
		logic       neg2;
	} div_side_t;

endpackage

### design/qrs_front.sv
// Front end: coefficient products and discriminant, two register stages.
// Depends on qrs_pkg.
module qrs_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
	output logic                               out_vld,
	output logic [qrs_pkg::MAG_W-1:0]          out_mag,
	output qrs_pkg::sqrt_side_t                out_side
);
	import qrs_pkg::*;

	localparam int PROD_W = 2 * COEF_W;
	localparam int DISC_W = PROD_W + 3;

	logic                     vld_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;
	logic signed [PROD_W-1:0] bb_s1, ac_s1;

	logic signed [DISC_W-1:0] disc;
	logic [DISC_W-1:0]        disc_abs;
	root_kind_t               kind;

	// Stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= coef_a;
		b_s1  <= coef_b;
		c_s1  <= coef_c;
		bb_s1 <= coef_b * coef_b;
		ac_s1 <= coef_a * coef_c;
	end

	// Stage 2: discriminant, its magnitude and the root kind
	always_comb begin
		disc     = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
		disc_abs = disc[DISC_W-1] ? (-disc) : disc;
		if (a_s1 == '0) begin
			kind = (b_s1 == '0) ? KIND_NONE : KIND_LINEAR;
		end else begin
			kind = disc[DISC_W-1] ? KIND_COMPLEX : KIND_REAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_mag       <= disc_abs[MAG_W-1:0];
		out_side.kind <= kind;
		out_side.a    <= a_s1;
		out_side.b    <= b_s1;
		out_side.c    <= c_s1;
	end

endmodule

### design/qrs_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [qrs_pkg::MAG_W-1:0]   in_mag,
	input  qrs_pkg::sqrt_side_t         in_side,
	output logic                        out_vld,
	output logic [qrs_pkg::SQRT_W-1:0]  out_root,
	output qrs_pkg::sqrt_side_t         out_side
);
	import qrs_pkg::*;

	localparam int REM_W = SQRT_W + 1;
	localparam int SH_W  = REM_W + 2;

	// Index k holds the inputs of stage k; index SQRT_W is the last register
	logic              vld_s  [0:SQRT_W];
	logic [MAG_W-1:0]  mag_s  [0:SQRT_W];
	logic [REM_W-1:0]  rem_s  [0:SQRT_W];
	logic [SQRT_W-1:0] res_s  [0:SQRT_W];
	sqrt_side_t        side_s [0:SQRT_W];

	assign vld_s[0]  = in_vld;
	assign mag_s[0]  = in_mag;
	assign rem_s[0]  = '0;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
		localparam int BIT = SQRT_W - 1 - k;
		logic [RAD_W-1:0] rad;
		logic [SH_W-1:0]  rem_sh;
		logic [SH_W-1:0]  trial;
		logic             take;

		// Bring down two radicand bits and try the next root bit
		always_comb begin
			rad    = RAD_W'({mag_s[k], {FRAC_SHIFT{1'b0}}});
			rem_sh = {rem_s[k], rad[2*BIT +: 2]};
			trial  = SH_W'({res_s[k], 2'b01});
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			mag_s[k+1]  <= mag_s[k];
			side_s[k+1] <= side_s[k];
			rem_s[k+1]  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			res_s[k+1]  <= {res_s[k][SQRT_W-2:0], take};
		end
	end

	assign out_vld  = vld_s[SQRT_W];
	assign out_root = res_s[SQRT_W];
	assign out_side = side_s[SQRT_W];

endmodule

### design/qrs_div.sv
// Pipelined two-lane restoring divider with a shared denominator,
// one quotient bit per stage. Depends on qrs_pkg.
module qrs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [qrs_pkg::NUM_W-1:0]  in_num1,
	input  logic [qrs_pkg::NUM_W-1:0]  in_num2,
	input  logic [qrs_pkg::DEN_W-1:0]  in_den,
	input  qrs_pkg::div_side_t         in_side,
	output logic                       out_vld,
	output logic [qrs_pkg::NUM_W-1:0]  out_q1,
	output logic [qrs_pkg::NUM_W-1:0]  out_q2,
	output qrs_pkg::div_side_t         out_side
);
	import qrs_pkg::*;

	localparam int SH_W = DEN_W + 1;

	logic             vld_s  [0:NUM_W];
	logic [NUM_W-1:0] num1_s [0:NUM_W];
	logic [NUM_W-1:0] num2_s [0:NUM_W];
	logic [DEN_W-1:0] den_s  [0:NUM_W];
	logic [DEN_W-1:0] rem1_s [0:NUM_W];
	logic [DEN_W-1:0] rem2_s [0:NUM_W];
	logic [NUM_W-1:0] q1_s   [0:NUM_W];
	logic [NUM_W-1:0] q2_s   [0:NUM_W];
	div_side_t        side_s [0:NUM_W];

	assign vld_s[0]  = in_vld;
	assign num1_s[0] = in_num1;
	assign num2_s[0] = in_num2;
	assign den_s[0]  = in_den;
	assign rem1_s[0] = '0;
	assign rem2_s[0] = '0;
	assign q1_s[0]   = '0;
	assign q2_s[0]   = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		localparam int BIT = NUM_W - 1 - k;
		logic [SH_W-1:0] sh1, sh2;
		logic            take1, take2;

		// Shift in the next numerator bit and trial-subtract in both lanes
		always_comb begin
			sh1   = {rem1_s[k], num1_s[k][BIT]};
			sh2   = {rem2_s[k], num2_s[k][BIT]};
			take1 = (sh1 >= SH_W'(den_s[k]));
			take2 = (sh2 >= SH_W'(den_s[k]));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			num1_s[k+1] <= num1_s[k];
			num2_s[k+1] <= num2_s[k];
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
			rem1_s[k+1] <= take1 ? DEN_W'(sh1 - SH_W'(den_s[k])) : sh1[DEN_W-1:0];
			rem2_s[k+1] <= take2 ? DEN_W'(sh2 - SH_W'(den_s[k])) : sh2[DEN_W-1:0];
			q1_s[k+1]   <= {q1_s[k][NUM_W-2:0], take1};
			q2_s[k+1]   <= {q2_s[k][NUM_W-2:0], take2};
		end
	end

	assign out_vld  = vld_s[NUM_W];
	assign out_q1   = q1_s[NUM_W];
	assign out_q2   = q2_s[NUM_W];
	assign out_side = side_s[NUM_W];

endmodule

### design/qrs_out.sv
// Output stage: sign restore, Q16.16 clipping and result register.
// Depends on qrs_pkg.
module qrs_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [qrs_pkg::NUM_W-1:0]   in_q1,
	input  logic [qrs_pkg::NUM_W-1:0]   in_q2,
	input  qrs_pkg::div_side_t          in_side,
	output logic                        done,
	output logic [1:0]                  root_kind,
	output logic signed [qrs_pkg::ROOT_W-1:0] root_first,
	output logic signed [qrs_pkg::ROOT_W-1:0] root_second,
	output logic                        saturated
);
	import qrs_pkg::*;

	localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(Q16_MAX);
	localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(Q16_MAX) + NUM_W'(1);

	logic [ROOT_W-1:0] v1, v2;
	logic              c1, c2;
	logic [ROOT_W-1:0] first_d, second_d;
	logic              sat_d;

	// Apply sign, clip to the Q16.16 range
	always_comb begin
		if (in_side.neg1) begin
			c1 = (in_q1 > NEG_LIM);
			v1 = c1 ? Q16_MIN : ROOT_W'(-in_q1);
		end else begin
			c1 = (in_q1 > POS_LIM);
			v1 = c1 ? Q16_MAX : in_q1[ROOT_W-1:0];
		end
		if (in_side.neg2) begin
			c2 = (in_q2 > NEG_LIM);
			v2 = c2 ? Q16_MIN : ROOT_W'(-in_q2);
		end else begin
			c2 = (in_q2 > POS_LIM);
			v2 = c2 ? Q16_MAX : in_q2[ROOT_W-1:0];
		end
		case (in_side.kind)
			KIND_LINEAR: begin
				first_d  = v1;
				second_d = '0;
				sat_d    = c1;
			end
			KIND_REAL, KIND_COMPLEX: begin
				first_d  = v1;
				second_d = v2;
				sat_d    = c1 | c2;
			end
			default: begin
				first_d  = '0;
				second_d = '0;
				sat_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		root_kind   <= in_side.kind;
		root_first  <= first_d;
		root_second <= second_d;
		saturated   <= sat_d;
	end

endmodule

### design/quadratic_root_solver_top.sv
// Quadratic root solver, fully pipelined: one coefficient set can be started
// every clock cycle (busy stays low) and its result appears with done after
// passing the 31-stage square root, the 33-stage divider and four register
// stages around them. The receiver cannot stall, so each result is on the
// ports for one cycle only.
// Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div and qrs_out.
module quadratic_root_solver_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_a,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_b,
	input  logic signed [qrs_pkg::COEF_W-1:0]  coef_c,
	output logic                               done,
	output logic [1:0]                         root_kind,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root_first,
	output logic signed [qrs_pkg::ROOT_W-1:0]  root_second,
	output logic                               saturated
);
	import qrs_pkg::*;

	logic              fr_vld;
	logic [MAG_W-1:0]  fr_mag;
	sqrt_side_t        fr_side;

	logic              sq_vld;
	logic [SQRT_W-1:0] sq_root;
	sqrt_side_t        sq_side;

	logic              vld_s3;
	logic [NUM_W-1:0]  num1_s3, num2_s3;
	logic [DEN_W-1:0]  den_s3;
	div_side_t         side_s3;

	logic              dv_vld;
	logic [NUM_W-1:0]  dv_q1, dv_q2;
	div_side_t         dv_side;

	logic signed [NUM_SW-1:0] root_x, nb_x, n1, n2;
	logic signed [COEF_W:0]   den_x;
	logic [COEF_W:0]          den_abs;
	logic [NUM_SW-1:0]        n1_abs, n2_abs;
	logic                     neg1, neg2;

	// Every pipeline stage advances each cycle
	assign busy = 1'b0;

	qrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.coef_a   (coef_a),
		.coef_b   (coef_b),
		.coef_c   (coef_c),
		.out_vld  (fr_vld),
		.out_mag  (fr_mag),
		.out_side (fr_side)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.in_mag   (fr_mag),
		.in_side  (fr_side),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// Numerator and denominator setup for each root kind
	always_comb begin
		root_x = NUM_SW'(sq_root);
		nb_x   = -(NUM_SW'(sq_side.b) <<< 14);
		n1     = '0;
		n2     = '0;
		den_x  = (COEF_W+1)'(sq_side.a);
		case (sq_side.kind)
			KIND_LINEAR: begin
				n1    = -(NUM_SW'(sq_side.c) <<< 16);
				den_x = (COEF_W+1)'(sq_side.b);
			end
			KIND_REAL: begin
				n1 = (nb_x + root_x) <<< 1;
				n2 = (nb_x - root_x) <<< 1;
			end
			KIND_COMPLEX: begin
				n1 = nb_x <<< 1;
				n2 = root_x <<< 1;
			end
			default: begin
				n1 = '0;
			end
		endcase
		den_abs = den_x[COEF_W] ? (-den_x) : den_x;
		n1_abs  = n1[NUM_SW-1] ? (-n1) : n1;
		n2_abs  = n2[NUM_SW-1] ? (-n2) : n2;
		neg1    = n1[NUM_SW-1] ^ den_x[COEF_W];
		// imaginary part is a magnitude; second real root sign is sign of n2 xor sign of a
		neg2    = (sq_side.kind == KIND_REAL) ? (n2[NUM_SW-1] ^ den_x[COEF_W]) : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		num1_s3       <= n1_abs[NUM_W-1:0];
		num2_s3       <= n2_abs[NUM_W-1:0];
		den_s3        <= den_abs[DEN_W-1:0];
		side_s3.kind  <= sq_side.kind;
		side_s3.neg1  <= neg1;
		side_s3.neg2  <= neg2;
	end

	qrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_num1  (num1_s3),
		.in_num2  (num2_s3),
		.in_den   (den_s3),
		.in_side  (side_s3),
		.out_vld  (dv_vld),
		.out_q1   (dv_q1),
		.out_q2   (dv_q2),
		.out_side (dv_side)
	);

	qrs_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (dv_vld),
		.in_q1       (dv_q1),
		.in_q2       (dv_q2),
		.in_side     (dv_side),
		.done        (done),
		.root_kind   (root_kind),
		.root_first  (root_first),
		.root_second (root_second),
		.saturated   (saturated)
	);

endmodule

### tb/qrs_checker.sv
// Checker for the quadratic root solver: watches the start and done channels,
// predicts each result from the coefficients and compares field by field.
// Depends on qrs_pkg for the root kind codes.
module qrs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] coef_a,
	input  logic [15:0] coef_b,
	input  logic [15:0] coef_c,
	input  logic        done,
	input  logic [1:0]  root_kind,
	input  logic [31:0] root_first,
	input  logic [31:0] root_second,
	input  logic        saturated,
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import qrs_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] first;
		logic [31:0] second;
		logic        sat;
	} roots_t;

	roots_t root_queue[$];

	// Integer square root, truncated
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Quotient toward zero, clipped to Q16.16
	function automatic logic [31:0] quot_clip(longint num, longint den, inout logic sat);
		longint q;
		q = num / den;
		if (q > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (q < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return q[31:0];
	endfunction

	function automatic roots_t solve_roots(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc);
		roots_t r;
		longint a, b, c, dn, nb, sq;
		a = longint'($signed(ra));
		b = longint'($signed(rb));
		c = longint'($signed(rc));
		r.sat = 1'b0;
		r.first = '0;
		r.second = '0;
		if (a == 0) begin
			if (b == 0) begin
				r.kind = KIND_NONE;
			end else begin
				r.kind = KIND_LINEAR;
				r.first = quot_clip(-c * 65536, b, r.sat);
			end
		end else begin
			dn = b * b - 4 * a * c;
			nb = -b * 16384;
			if (dn >= 0) begin
				sq = longint'(int_sqrt(longint'(dn) << 28));
				r.kind = KIND_REAL;
				r.first = quot_clip(2 * (nb + sq), a, r.sat);
				r.second = quot_clip(2 * (nb - sq), a, r.sat);
			end else begin
				sq = longint'(int_sqrt(longint'(-dn) << 28));
				r.kind = KIND_COMPLEX;
				r.first = quot_clip(2 * nb, a, r.sat);
				r.second = quot_clip(2 * sq, (a < 0) ? -a : a, r.sat);
			end
		end
		return r;
	endfunction

	assign pending = root_queue.size();

	// Predict on accepted transactions, compare on done
	always @(posedge clk or negedge arst_n) begin
		roots_t e;
		if (!arst_n) begin
			fail_count <= 0;
			checked <= 0;
		end else begin
			if (done) begin
				if (root_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result kind=%0d first=%h second=%h",
							root_kind, root_first, root_second);
				end else begin
					e = root_queue.pop_front();
					checked <= checked + 1;
					if (e.kind !== root_kind || e.first !== root_first ||
						e.second !== root_second || e.sat !== saturated) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch exp %0d %h %h %b got %0d %h %h %b",
								e.kind, e.first, e.second, e.sat,
								root_kind, root_first, root_second, saturated);
					end
				end
			end
			if (start && !busy)
				root_queue.push_back(solve_roots(coef_a, coef_b, coef_c));
		end
	end
endmodule

### tb/tb.sv
// Testbench top for the quadratic root solver: clock, reset, stimulus, verdict.
// Depends on qrs_pkg, quadratic_root_solver_top and qrs_checker.
module tb;
	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [15:0] coef_a, coef_b, coef_c;
	logic done;
	logic [1:0] root_kind;
	logic [31:0] root_first, root_second;
	logic saturated;
	int fail_count, pending, checked;
	int sent;

	quadratic_root_solver_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.done(done), .root_kind(root_kind), .root_first(root_first),
		.root_second(root_second), .saturated(saturated)
	);

	qrs_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.done(done), .root_kind(root_kind), .root_first(root_first),
		.root_second(root_second), .saturated(saturated),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Random coefficient: often fully random, sometimes small, whole, extreme or zero
	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
			2, 3: return 16'($signed($urandom_range(0, 1023)) - 512);
			4: return 16'($urandom_range(0, 15)) << 8;
			default: return 16'($urandom());
		endcase
	endfunction

	// One transaction; start held while back-to-back items follow
	task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		start <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic idle_burst(int n);
		start <= 1'b0;
		coef_a <= 16'($urandom());
		coef_b <= 16'($urandom());
		coef_c <= 16'($urandom());
		repeat (n) @(negedge clk);
	endtask

	initial begin
		#2000000;
		$display("tb failed");
		$finish;
	end

	initial begin
		logic [15:0] ext[4];
		int waited;
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		coef_a = '0;
		coef_b = '0;
		coef_c = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: no solution, linear, real, complex, negative a complex, extremes
		send_coefs(16'h0000, 16'h0000, 16'h1234);
		send_coefs(16'h0000, 16'h0100, 16'h0300);
		send_coefs(16'h0000, 16'h0001, 16'h8000);
		send_coefs(16'h0100, 16'h0000, 16'hfc00);
		send_coefs(16'h0100, 16'h0200, 16'h0500);
		send_coefs(16'hff00, 16'h0200, 16'hfb00);
		send_coefs(16'h0001, 16'h7fff, 16'h0000);
		send_coefs(16'h0100, 16'h0200, 16'h0100);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				send_coefs(ext[i], ext[j], ext[(i + j) % 4]);

		// Random with idle bursts, then a final stretch without gaps
		for (int n = 0; n < 950; n++) begin
			if (n < 800 && $urandom_range(0, 7) == 0)
				idle_burst($urandom_range(1, 19));
			send_coefs(pick_coef(), pick_coef(), pick_coef());
		end
		start <= 1'b0;

		waited = 0;
		while ((pending != 0 || waited < 80) && waited < 2000) begin
			@(posedge clk);
			if (pending == 0) waited++;
			else waited = 0;
		end
		$display("sent %0d coefficient sets, checked %0d results", sent, checked);
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
